@@ rtl/hkprd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hkprd_pkg
// Shared codes, key codes and key class helpers for the hotkey detector.
// ----------------------------------------------------------------------------
package hkprd_pkg;

   // event commands
   localparam logic [1:0] CMD_DOWN  = 2'd0;
   localparam logic [1:0] CMD_UP    = 2'd1;
   localparam logic [1:0] CMD_PASS  = 2'd2;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   // result codes
   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2
   } event_type;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_KEY     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NEED_CTRL      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NEED_ALT       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NEED_SHIFT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NEED_WIN       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NEED_CAPS      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MODIFIERS_ONLY = 3'd6;

   // virtual key codes
   localparam logic [7:0] VK_SHIFT_ANY   = 8'h10;
   localparam logic [7:0] VK_CTRL_ANY    = 8'h11;
   localparam logic [7:0] VK_ALT_ANY     = 8'h12;
   localparam logic [7:0] VK_CAPS        = 8'h14;
   localparam logic [7:0] VK_LEFT_WIN    = 8'h5B;
   localparam logic [7:0] VK_RIGHT_WIN   = 8'h5C;
   localparam logic [7:0] VK_SHIFT_LEFT  = 8'hA0;
   localparam logic [7:0] VK_SHIFT_RIGHT = 8'hA1;
   localparam logic [7:0] VK_LCTRL       = 8'hA2;
   localparam logic [7:0] VK_RCTRL       = 8'hA3;
   localparam logic [7:0] VK_LALT        = 8'hA4;
   localparam logic [7:0] VK_RALT        = 8'hA5;

   function automatic logic is_ctrl(input logic [7:0] k);
      return (k == VK_CTRL_ANY) || (k == VK_LCTRL) || (k == VK_RCTRL);
   endfunction

   function automatic logic is_alt(input logic [7:0] k);
      return (k == VK_ALT_ANY) || (k == VK_LALT) || (k == VK_RALT);
   endfunction

   function automatic logic is_shift(input logic [7:0] k);
      return (k == VK_SHIFT_ANY) || (k == VK_SHIFT_LEFT) || (k == VK_SHIFT_RIGHT);
   endfunction

   function automatic logic is_win(input logic [7:0] k);
      return (k == VK_LEFT_WIN) || (k == VK_RIGHT_WIN);
   endfunction

endpackage
`default_nettype wire

@@ rtl/hotkey_press_release_detector_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hotkey_press_release_detector_unit
// An accepted key word's result word is registered in the cycle after it is
// accepted. Throughput: one word per cycle while results are taken; the result
// register frees as it is taken. The single flag-update pass lies between the
// request port and the result register. Synchronous active-high reset clears
// modifier tracking, the hotkey state and all configuration registers.
// ----------------------------------------------------------------------------
module hotkey_press_release_detector_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // key event word
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [1:0]                     req_cmd,
   input  wire logic [7:0]                     req_key_code,
   input  wire logic                           req_ctrl_held,
   input  wire logic                           req_alt_held,
   input  wire logic                           req_shift_held,
   input  wire logic                           req_left_win_held,
   input  wire logic                           req_right_win_held,
   input  wire logic                           req_caps_held,
   input  wire logic                           req_target_held,
   // result word
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic [1:0]                     rsp_hotkey_event,
   output      logic                           rsp_swallow,
   // configuration writes
   input  wire logic                           csr_wr_en,
   input  wire logic [hkprd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]                     csr_wdata
);

   // configuration
   logic [7:0] target_key_ff;
   logic       need_ctrl_ff, need_alt_ff, need_shift_ff;
   logic       need_win_ff, need_caps_ff, modifiers_only_ff;

   // tracked state
   logic active_ff, active_in;
   logic block_ff, block_in;
   logic ctrl_ff, ctrl_in, alt_ff, alt_in, shift_ff, shift_in;
   logic lwin_ff, lwin_in, rwin_ff, rwin_in, caps_ff, caps_in;

   // result register
   logic       rsp_valid_ff;
   logic [1:0] rsp_event_ff;
   logic       rsp_swallow_ff;

   hkprd_pkg::event_type ev;
   logic swallow;
   logic accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hotkey_event = rsp_event_ff;
   assign rsp_swallow      = rsp_swallow_ff;

   // take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_key_ff     <= '0;
         need_ctrl_ff      <= 1'b0;
         need_alt_ff       <= 1'b0;
         need_shift_ff     <= 1'b0;
         need_win_ff       <= 1'b0;
         need_caps_ff      <= 1'b0;
         modifiers_only_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hkprd_pkg::REG_TARGET_KEY:     target_key_ff     <= csr_wdata;
            hkprd_pkg::REG_NEED_CTRL:      need_ctrl_ff      <= csr_wdata[0];
            hkprd_pkg::REG_NEED_ALT:       need_alt_ff       <= csr_wdata[0];
            hkprd_pkg::REG_NEED_SHIFT:     need_shift_ff     <= csr_wdata[0];
            hkprd_pkg::REG_NEED_WIN:       need_win_ff       <= csr_wdata[0];
            hkprd_pkg::REG_NEED_CAPS:      need_caps_ff      <= csr_wdata[0];
            hkprd_pkg::REG_MODIFIERS_ONLY: modifiers_only_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // evaluate one key word against the tracked state
   always_comb begin
      logic down, up, is_mod, req_ev, held, hit;
      down   = (req_cmd == hkprd_pkg::CMD_DOWN);
      up     = (req_cmd == hkprd_pkg::CMD_UP);
      hit    = (req_key_code == target_key_ff);
      is_mod = hkprd_pkg::is_ctrl(req_key_code) || hkprd_pkg::is_alt(req_key_code) ||
               hkprd_pkg::is_shift(req_key_code) || hkprd_pkg::is_win(req_key_code) ||
               (req_key_code == hkprd_pkg::VK_CAPS);
      req_ev = (need_ctrl_ff && hkprd_pkg::is_ctrl(req_key_code)) ||
               (need_alt_ff && hkprd_pkg::is_alt(req_key_code)) ||
               (need_shift_ff && hkprd_pkg::is_shift(req_key_code)) ||
               (need_win_ff && hkprd_pkg::is_win(req_key_code)) ||
               (need_caps_ff && (req_key_code == hkprd_pkg::VK_CAPS));
      held   = 1'b0;

      ev        = hkprd_pkg::EV_NONE;
      swallow   = 1'b0;
      active_in = active_ff;
      block_in  = block_ff;
      ctrl_in   = ctrl_ff;
      alt_in    = alt_ff;
      shift_in  = shift_ff;
      lwin_in   = lwin_ff;
      rwin_in   = rwin_ff;
      caps_in   = caps_ff;

      if (down || up) begin
         // swallow CapsLock when it is required, and blocked required modifiers
         if (need_caps_ff && (req_key_code == hkprd_pkg::VK_CAPS)) swallow = 1'b1;
         if (block_ff && req_ev) swallow = 1'b1;

         // refresh modifier tracking on a modifier key
         if (is_mod) begin
            ctrl_in  = hkprd_pkg::is_ctrl(req_key_code) ? down : req_ctrl_held;
            alt_in   = hkprd_pkg::is_alt(req_key_code) ? down : req_alt_held;
            shift_in = hkprd_pkg::is_shift(req_key_code) ? down : req_shift_held;
            lwin_in  = (req_key_code == hkprd_pkg::VK_LEFT_WIN) ? down : req_left_win_held;
            rwin_in  = (req_key_code == hkprd_pkg::VK_RIGHT_WIN) ? down : req_right_win_held;
            caps_in  = (req_key_code == hkprd_pkg::VK_CAPS) ? down : req_caps_held;
         end

         held = !(need_ctrl_ff && !ctrl_in) && !(need_alt_ff && !alt_in) &&
                !(need_shift_ff && !shift_in) && !(need_win_ff && !(lwin_in || rwin_in)) &&
                !(need_caps_ff && !caps_in);

         // end the press on a released required modifier
         if (active_in && up && req_ev && !held) begin
            active_in = 1'b0;
            ev        = hkprd_pkg::EV_RELEASE;
         end

         // end the press when the target release was missed
         if (active_in && !modifiers_only_ff && !hit && !req_target_held) begin
            active_in = 1'b0;
            ev        = hkprd_pkg::EV_RELEASE;
         end

         if (modifiers_only_ff) begin
            if (down) begin
               if (!active_in && held) begin
                  active_in = 1'b1;
                  ev        = hkprd_pkg::EV_PRESS;
               end
            end else if (active_in && !held) begin
               active_in = 1'b0;
               ev        = hkprd_pkg::EV_RELEASE;
            end
         end else begin
            if (hit) begin
               if (down) begin
                  if (held) begin
                     swallow = 1'b1;
                     if (!active_in) begin
                        active_in = 1'b1;
                        block_in  = 1'b1;
                        ev        = hkprd_pkg::EV_PRESS;
                     end
                  end
               end else if (active_in) begin
                  swallow   = 1'b1;
                  active_in = 1'b0;
                  ev        = hkprd_pkg::EV_RELEASE;
               end
            end
            // drop the modifier block once a required modifier is up
            if (block_in && !held) block_in = 1'b0;
         end
      end
   end

   // advance tracked state on an accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         block_ff  <= 1'b0;
         ctrl_ff   <= 1'b0;
         alt_ff    <= 1'b0;
         shift_ff  <= 1'b0;
         lwin_ff   <= 1'b0;
         rwin_ff   <= 1'b0;
         caps_ff   <= 1'b0;
      end else if (accept) begin
         active_ff <= active_in;
         block_ff  <= block_in;
         ctrl_ff   <= ctrl_in;
         alt_ff    <= alt_in;
         shift_ff  <= shift_in;
         lwin_ff   <= lwin_in;
         rwin_ff   <= rwin_in;
         caps_ff   <= caps_in;
      end
   end

   // hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_event_ff   <= ev;
         rsp_swallow_ff <= swallow;
      end
   end

endmodule
`default_nettype wire
